FILE: sv/rsq_pkg.sv
// ----------------------------------------------------------------------------
// Smallest-three quaternion encoder package
// Shared constants, beat payload types and pipeline depths.
// ----------------------------------------------------------------------------
package rsq_pkg;

	localparam int INPUT_FRAC_BITS_DEF = 14;
	localparam int FIFO_DEPTH_DEF      = 2;

	localparam int COMP_W      = 32;
	localparam int ABS_W       = 31;
	localparam int NORM_STAGES = 5;
	localparam int SQRT_STAGES = 32;
	localparam int QUO_BITS    = 16;
	localparam int LANE_LAT    = QUO_BITS + 4;
	localparam int SIDE_LAT    = 3 + NORM_STAGES + SQRT_STAGES;
	localparam int BACK_LAT    = SIDE_LAT + LANE_LAT;

	localparam logic signed [23:0] SCALE_K = 24'sd4634095;
	localparam int SAT_MAX = 32767;

	typedef struct packed {
		logic [3:0][ABS_W-1:0]  absq;
		logic [2:0][COMP_W-1:0] kept;
		logic [1:0]             idx;
	} item_t;

	typedef struct packed {
		logic [2:0][COMP_W-1:0] kept;
		logic [1:0]             idx;
		logic [4:0]             g;
	} side_t;

endpackage

FILE: sv/rsq_front.sv
// ----------------------------------------------------------------------------
// Front end
// Builds the unnormalized quaternion and classifies the dropped component.
// ----------------------------------------------------------------------------
module rsq_front #(
	parameter int INPUT_FRAC_BITS = rsq_pkg::INPUT_FRAC_BITS_DEF
) (
	input  logic signed [15:0] m11,
	input  logic signed [15:0] m12,
	input  logic signed [15:0] m13,
	input  logic signed [15:0] m21,
	input  logic signed [15:0] m22,
	input  logic signed [15:0] m23,
	input  logic signed [15:0] m31,
	input  logic signed [15:0] m32,
	input  logic signed [15:0] m33,
	output rsq_pkg::item_t     item
);

	localparam int ONE = 1 << INPUT_FRAC_BITS;

	logic signed [31:0] one_w;
	logic signed [31:0] e11, e12, e13, e21, e22, e23, e31, e32, e33;
	logic signed [31:0] q [4];
	logic [1:0] idx;
	logic neg;

	assign one_w = 32'(ONE);
	assign e11 = 32'(m11);
	assign e12 = 32'(m12);
	assign e13 = 32'(m13);
	assign e21 = 32'(m21);
	assign e22 = 32'(m22);
	assign e23 = 32'(m23);
	assign e31 = 32'(m31);
	assign e32 = 32'(m32);
	assign e33 = 32'(m33);

	always_comb begin
		if (e33 < 0) begin
			if (e11 > e22) begin
				q[0] = one_w + e11 - e22 - e33;
				q[1] = e12 + e21;
				q[2] = e31 + e13;
				q[3] = e23 - e32;
			end else begin
				q[0] = e12 + e21;
				q[1] = one_w - e11 + e22 - e33;
				q[2] = e23 + e32;
				q[3] = e31 - e13;
			end
		end else begin
			if (e11 + e22 < 0) begin
				q[0] = e31 + e13;
				q[1] = e23 + e32;
				q[2] = one_w - e11 - e22 + e33;
				q[3] = e12 - e21;
			end else begin
				q[0] = e23 - e32;
				q[1] = e31 - e13;
				q[2] = e12 - e21;
				q[3] = one_w + e11 + e22 + e33;
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			item.absq[i] = q[i][31] ? 31'(-q[i]) : 31'(q[i]);
		end
		idx = 2'd0;
		for (int i = 1; i < 4; i++) begin
			if (item.absq[i] > item.absq[idx]) begin
				idx = 2'(i);
			end
		end
		neg = q[idx][31];
		for (int j = 0; j < 3; j++) begin
			if (2'(j) < idx) begin
				item.kept[j] = neg ? -q[j] : q[j];
			end else begin
				item.kept[j] = neg ? -q[j+1] : q[j+1];
			end
		end
		item.idx = idx;
	end

endmodule

FILE: sv/rsq_fifo.sv
// ----------------------------------------------------------------------------
// Front-to-back queue
// Short queue that lets the front and the back pipeline stall apart.
// ----------------------------------------------------------------------------
module rsq_fifo #(
	parameter int DEPTH = rsq_pkg::FIFO_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  rsq_pkg::item_t wdata,
	output logic           full,
	input  logic           pop,
	output rsq_pkg::item_t rdata,
	output logic           empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	rsq_pkg::item_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) !(push && full))
		else $error("Queue written while full.");
	assert property (@(posedge clk) disable iff (!arst_n) !(pop && empty))
		else $error("Queue read while empty.");
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("Queue count did not follow a lone write.");

endmodule

FILE: sv/rsq_div.sv
// ----------------------------------------------------------------------------
// Scaling lane
// Scales one kept component by the constant over the magnitude, rounds and
// saturates it through a pipelined restoring divider.
// ----------------------------------------------------------------------------
module rsq_div (
	input  logic               clk,
	input  logic               en,
	input  logic signed [31:0] a,
	input  logic [4:0]         g,
	input  logic [31:0]        mag,
	output logic signed [15:0] result
);

	localparam int QB = rsq_pkg::QUO_BITS;

	logic signed [32:0] b;
	logic signed [55:0] p_s1;
	logic [38:0]        m100_s1;
	logic               mz_s1;
	logic signed [57:0] num_s2;
	logic [39:0]        den_s2;
	logic               mz_s2;
	logic [56:0]        rem_s3;
	logic [39:0]        den_s3;
	logic               neg_s3, mz_s3;

	logic [56:0]   rem_q [QB];
	logic [QB-1:0] quo_q [QB];
	logic [39:0]   den_q [QB];
	logic          neg_q [QB];
	logic          mz_q  [QB];

	logic [16:0]        qv;
	logic signed [17:0] sv;

	assign b = 33'(a) <<< g;

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1    <= b * rsq_pkg::SCALE_K;
			m100_s1 <= mag * 7'd100;
			mz_s1   <= (mag == '0);
			num_s2  <= (58'(p_s1) <<< 1) + signed'(58'(m100_s1));
			den_s2  <= {m100_s1, 1'b0};
			mz_s2   <= mz_s1;
			rem_s3  <= num_s2[57] ? 57'(-num_s2) : 57'(num_s2);
			neg_s3  <= num_s2[57];
			den_s3  <= den_s2;
			mz_s3   <= mz_s2;
		end
	end

	for (genvar j = 0; j < QB; j++) begin : g_div
		logic [56:0]   rem_in;
		logic [QB-1:0] quo_in;
		logic [39:0]   den_in;
		logic          neg_in, mz_in;
		logic [57:0]   trial;
		logic          ge;

		if (j == 0) begin : g_first
			assign rem_in = rem_s3;
			assign quo_in = '0;
			assign den_in = den_s3;
			assign neg_in = neg_s3;
			assign mz_in  = mz_s3;
		end else begin : g_next
			assign rem_in = rem_q[j-1];
			assign quo_in = quo_q[j-1];
			assign den_in = den_q[j-1];
			assign neg_in = neg_q[j-1];
			assign mz_in  = mz_q[j-1];
		end

		assign trial = 58'(den_in) << (QB - 1 - j);
		assign ge    = ({1'b0, rem_in} >= trial);

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[j] <= ge ? 57'({1'b0, rem_in} - trial) : rem_in;
				quo_q[j] <= {quo_in[QB-2:0], ge};
				den_q[j] <= den_in;
				neg_q[j] <= neg_in;
				mz_q[j]  <= mz_in;
			end
		end
	end

	assign qv = 17'(quo_q[QB-1]) + 17'(neg_q[QB-1] && (rem_q[QB-1] != '0));
	assign sv = neg_q[QB-1] ? -signed'({1'b0, qv}) : signed'({1'b0, qv});

	always_ff @(posedge clk) begin
		if (en) begin
			if (mz_q[QB-1]) begin
				result <= '0;
			end else if (sv > 18'(rsq_pkg::SAT_MAX)) begin
				result <= 16'(rsq_pkg::SAT_MAX);
			end else if (sv < -18'(rsq_pkg::SAT_MAX)) begin
				result <= 16'(-rsq_pkg::SAT_MAX);
			end else begin
				result <= 16'(sv);
			end
		end
	end

endmodule

FILE: sv/rsq_back.sv
// ----------------------------------------------------------------------------
// Back end
// Sum of squares, normalization, pipelined square root and three scaling
// lanes, all advancing together under one enable.
// ----------------------------------------------------------------------------
module rsq_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  rsq_pkg::item_t     item,
	output logic               out_valid,
	output logic signed [15:0] q_first,
	output logic signed [15:0] q_second,
	output logic signed [15:0] q_third,
	output logic [1:0]         dropped_index
);

	localparam int NS = rsq_pkg::NORM_STAGES;
	localparam int SS = rsq_pkg::SQRT_STAGES;
	localparam int SL = rsq_pkg::SIDE_LAT;
	localparam int LL = rsq_pkg::LANE_LAT;
	localparam int BL = rsq_pkg::BACK_LAT;

	logic [BL-1:0]  vld_q;
	rsq_pkg::side_t side_q [SL];
	logic [1:0]     idx_q  [LL];

	logic [61:0] sq_s1 [4];
	logic [62:0] pr_s2 [2];
	logic [63:0] s_s3;
	logic [63:0] nrm_q [NS];
	logic [4:0]  g_add [NS];
	logic [63:0] sqn_q [SS];
	logic [63:0] sqr_q [SS];

	logic signed [15:0] res [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[BL-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				sq_s1[i] <= 62'(item.absq[i]) * 62'(item.absq[i]);
			end
			pr_s2[0] <= 63'(sq_s1[0]) + 63'(sq_s1[1]);
			pr_s2[1] <= 63'(sq_s1[2]) + 63'(sq_s1[3]);
			s_s3     <= 64'(pr_s2[0]) + 64'(pr_s2[1]);
			side_q[0].kept <= item.kept;
			side_q[0].idx  <= item.idx;
			side_q[0].g    <= '0;
			for (int i = 1; i < 3; i++) begin
				side_q[i] <= side_q[i-1];
			end
			for (int i = 0; i < NS; i++) begin
				side_q[3+i].kept <= side_q[2+i].kept;
				side_q[3+i].idx  <= side_q[2+i].idx;
				side_q[3+i].g    <= side_q[2+i].g + g_add[i];
			end
			for (int i = 3 + NS; i < SL; i++) begin
				side_q[i] <= side_q[i-1];
			end
			idx_q[0] <= side_q[SL-1].idx;
			for (int i = 1; i < LL; i++) begin
				idx_q[i] <= idx_q[i-1];
			end
		end
	end

	for (genvar i = 0; i < NS; i++) begin : g_norm
		localparam int K = 16 >> i;
		logic [63:0] n_in;
		logic        sh;

		if (i == 0) begin : g_first
			assign n_in = s_s3;
		end else begin : g_next
			assign n_in = nrm_q[i-1];
		end

		assign sh       = (n_in[63 -: 2*K] == '0);
		assign g_add[i] = sh ? 5'(K) : 5'd0;

		always_ff @(posedge clk) begin
			if (en) begin
				nrm_q[i] <= sh ? (n_in << (2*K)) : n_in;
			end
		end
	end

	for (genvar k = 0; k < SS; k++) begin : g_sqrt
		localparam logic [63:0] BIT = 64'd1 << (62 - 2*k);
		logic [63:0] n_in, r_in, t;

		if (k == 0) begin : g_first
			assign n_in = nrm_q[NS-1];
			assign r_in = '0;
		end else begin : g_next
			assign n_in = sqn_q[k-1];
			assign r_in = sqr_q[k-1];
		end

		assign t = r_in + BIT;

		always_ff @(posedge clk) begin
			if (en) begin
				if (n_in >= t) begin
					sqn_q[k] <= n_in - t;
					sqr_q[k] <= (r_in >> 1) + BIT;
				end else begin
					sqn_q[k] <= n_in;
					sqr_q[k] <= r_in >> 1;
				end
			end
		end
	end

	for (genvar j = 0; j < 3; j++) begin : g_lane
		rsq_div u_div (
			.clk    (clk),
			.en     (en),
			.a      (signed'(side_q[SL-1].kept[j])),
			.g      (side_q[SL-1].g),
			.mag    (sqr_q[SS-1][31:0]),
			.result (res[j])
		);
	end

	assign out_valid     = vld_q[BL-1];
	assign q_first       = res[0];
	assign q_second      = res[1];
	assign q_third       = res[2];
	assign dropped_index = idx_q[LL-1];

endmodule

FILE: sv/rotation_smallest_three_quat_encoder.sv
// ----------------------------------------------------------------------------
// Rotation matrix to smallest-three quaternion encoder
// Top level: stream ports, front end, queue and back pipeline.
// ----------------------------------------------------------------------------
// The block takes one matrix beat per clock and returns one encoded beat per
// clock for as long as the output side keeps tready high. An accepted beat
// waits in the queue, then passes three stages for the sum of squares, five
// for normalization, 32 for the bit-per-stage square root and 20 for the
// pipelined scaling divider, entering the first of them at the edge that
// takes it from the queue. The output register holds a finished beat while
// tready is low; the two-entry queue then absorbs input until it is full.
module rotation_smallest_three_quat_encoder #(
	parameter int INPUT_FRAC_BITS = rsq_pkg::INPUT_FRAC_BITS_DEF,
	parameter int FIFO_DEPTH      = rsq_pkg::FIFO_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// m11, m12, m13, m21, m22, m23, m31, m32, m33, 16 bits each
	input  logic [143:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// q_first, q_second, q_third, 16 bits each
	output logic [47:0]  m_tdata,
	// dropped_index
	output logic [1:0]   m_tuser
);

	rsq_pkg::item_t front_item, head_item;
	logic full, empty, push, pop, en;
	logic signed [15:0] q_first, q_second, q_third;

	rsq_front #(
		.INPUT_FRAC_BITS (INPUT_FRAC_BITS)
	) u_front (
		.m11  (signed'(s_tdata[15:0])),
		.m12  (signed'(s_tdata[31:16])),
		.m13  (signed'(s_tdata[47:32])),
		.m21  (signed'(s_tdata[63:48])),
		.m22  (signed'(s_tdata[79:64])),
		.m23  (signed'(s_tdata[95:80])),
		.m31  (signed'(s_tdata[111:96])),
		.m32  (signed'(s_tdata[127:112])),
		.m33  (signed'(s_tdata[143:128])),
		.item (front_item)
	);

	assign s_tready = !full;
	assign push     = s_tvalid && !full;
	assign en       = !m_tvalid || m_tready;
	assign pop      = en && !empty;

	rsq_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (front_item),
		.full   (full),
		.pop    (pop),
		.rdata  (head_item),
		.empty  (empty)
	);

	rsq_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en),
		.in_valid      (pop),
		.item          (head_item),
		.out_valid     (m_tvalid),
		.q_first       (q_first),
		.q_second      (q_second),
		.q_third       (q_third),
		.dropped_index (m_tuser)
	);

	assign m_tdata = {q_third, q_second, q_first};

endmodule

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// Smallest-three quaternion encoder testbench
// Drives rotation matrices, predicts the encoded quaternion and checks beats.
// ----------------------------------------------------------------------------
// Directed matrices cover the identity, the four branches, ties for the
// largest component, negative dropped components and the full 16-bit
// extremes. Random matrices follow: mostly entries within +-1.0, plus some
// with any 16-bit pattern. Input bursts are random; output stalls are partly random.
// ----------------------------------------------------------------------------
class quat_scoreboard;
	logic [49:0] pending[$];
	int errors;

	function automatic longint isqrt(longint unsigned n);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv >>= 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return longint'(res);
	endfunction

	function automatic logic [49:0] encode(logic [143:0] d);
		longint m[9], q[4], den, a, num, r, magv;
		longint unsigned sq, aq[4];
		int idx, g, w;
		logic [49:0] res;
		longint one;
		one = 64'sd1 << 14;
		for (int i = 0; i < 9; i++) m[i] = longint'($signed(d[i*16 +: 16]));
		if (m[8] < 0) begin
			if (m[0] > m[4]) begin
				q[0] = one + m[0] - m[4] - m[8];
				q[1] = m[1] + m[3]; q[2] = m[6] + m[2]; q[3] = m[5] - m[7];
			end else begin
				q[0] = m[1] + m[3]; q[1] = one - m[0] + m[4] - m[8];
				q[2] = m[5] + m[7]; q[3] = m[6] - m[2];
			end
		end else if (m[0] + m[4] < 0) begin
			q[0] = m[6] + m[2]; q[1] = m[5] + m[7];
			q[2] = one - m[0] - m[4] + m[8]; q[3] = m[1] - m[3];
		end else begin
			q[0] = m[5] - m[7]; q[1] = m[6] - m[2]; q[2] = m[1] - m[3];
			q[3] = one + m[0] + m[4] + m[8];
		end
		sq = 0;
		for (int i = 0; i < 4; i++) begin
			aq[i] = (q[i] < 0) ? -q[i] : q[i];
			sq += aq[i] * aq[i];
		end
		idx = 0;
		for (int i = 1; i < 4; i++) if (aq[i] > aq[idx]) idx = i;
		magv = 0;
		g = 0;
		if (sq != 0) begin
			while (g < 31 && (sq >> 62) == 0) begin
				sq <<= 2;
				g++;
			end
			magv = isqrt(sq);
		end
		res = '0;
		w = 0;
		for (int i = 0; i < 4; i++) begin
			if (i != idx) begin
				r = 0;
				if (magv > 0) begin
					a = (q[idx] < 0) ? -q[i] : q[i];
					num = 2 * (a <<< g) * 4634095 + 100 * magv;
					den = 200 * magv;
					r = (num >= 0) ? num / den : -((-num + den - 1) / den);
					if (r > 32767) r = 32767;
					if (r < -32767) r = -32767;
				end
				res[w*16 +: 16] = r[15:0];
				w++;
			end
		end
		res[49:48] = idx[1:0];
		return res;
	endfunction

	function void note_matrix(logic [143:0] d);
		pending = {pending, encode(d)};
	endfunction

	function void check_beat(logic [47:0] qd, logic [1:0] di);
		logic [49:0] e;
		string names[3];
		names = '{"q_first", "q_second", "q_third"};
		if (pending.size() == 0) begin
			$error("unexpected output beat %h %0d", qd, di);
			errors++;
			return;
		end
		e = pending.pop_front();
		for (int k = 0; k < 3; k++) begin
			if (qd[k*16 +: 16] !== e[k*16 +: 16]) begin
				$error("%s: expected %0d, actual %0d", names[k],
					$signed(e[k*16 +: 16]), $signed(qd[k*16 +: 16]));
				errors++;
			end
		end
		if (di !== e[49:48]) begin
			$error("dropped_index: expected %0d, actual %0d", e[49:48], di);
			errors++;
		end
	endfunction
endclass

module tb_top;
	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [143:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [47:0]  m_tdata;
	logic [1:0]   m_tuser;

	quat_scoreboard sb;
	int idle_cycles;
	bit stim_done;

	rotation_smallest_three_quat_encoder u_top (.*);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	function automatic logic [143:0] pack9(int v[9]);
		logic [143:0] d;
		for (int i = 0; i < 9; i++) d[i*16 +: 16] = v[i][15:0];
		return d;
	endfunction

	function automatic logic [143:0] random_matrix();
		logic [143:0] d;
		int sel;
		sel = $urandom_range(0, 9);
		for (int i = 0; i < 9; i++) begin
			if (sel == 0) d[i*16 +: 16] = 16'($urandom);
			else if (sel == 1) d[i*16 +: 16] = 16'($urandom_range(0, 4) * 8192 - 16384);
			else d[i*16 +: 16] = 16'($signed($urandom_range(0, 32768)) - 16384);
		end
		return d;
	endfunction

	task automatic send_matrix(logic [143:0] d);
		s_tdata <= d;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		sb.note_matrix(d);
		@(negedge clk);
	endtask

	task automatic send_gap();
		s_tvalid <= 1'b0;
		repeat ($urandom_range(1, 6)) @(negedge clk);
	endtask

	initial begin
		int dir[20][9];
		int burst;
		sb = new();
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = '0;
		stim_done = 0;
		dir = '{
			'{16384, 0, 0, 0, 16384, 0, 0, 0, 16384},
			'{16384, 0, 0, 0, -16384, 0, 0, 0, -16384},
			'{-16384, 0, 0, 0, 16384, 0, 0, 0, -16384},
			'{-16384, 0, 0, 0, -16384, 0, 0, 0, 16384},
			'{0, -16384, 0, 16384, 0, 0, 0, 0, 16384},
			'{-16384, 0, 0, 0, 0, 16384, 0, -16384, 0},
			'{0, 0, 16384, 0, 16384, 0, -16384, 0, 0},
			'{-16384, 0, 0, 0, -16384, 0, 0, 0, -16384},
			'{0, 0, 0, 0, 0, 0, 0, 0, 0},
			'{-8192, 0, 0, 0, -8192, 0, 0, 0, 0},
			'{0, 0, 0, 0, 0, 0, 0, 0, -16384},
			'{-16384, 0, 0, 0, 0, 0, 0, 0, 0},
			'{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767},
			'{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768},
			'{32767, -32768, 32767, -32768, -32768, 32767, -32768, 32767, -32768},
			'{-1, -1, -1, -1, -1, -1, -1, -1, -1},
			'{1, 1, 1, 1, 1, 1, 1, 1, 1},
			'{0, 16384, 0, -16384, 0, 0, 0, 0, 1},
			'{11585, -11585, 0, 11585, 11585, 0, 0, 0, 16384},
			'{16384, 0, 0, 0, 16384, 0, 0, 0, -16384}
		};
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		foreach (dir[i]) send_matrix(pack9(dir[i]));
		send_gap();
		for (int n = 0; n < 1150; ) begin
			burst = $urandom_range(1, 40);
			for (int b = 0; b < burst; b++, n++) send_matrix(random_matrix());
			if ($urandom_range(0, 3) != 0) send_gap();
		end
		s_tvalid <= 1'b0;
		stim_done = 1;
	end

	initial begin
		int phase;
		m_tready = 0;
		forever begin
			@(negedge clk);
			phase = (phase + 1) % 300;
			if (phase < 60) m_tready <= 1'b1;
			else if (phase < 150) m_tready <= ($urandom_range(0, 2) != 0);
			else if (phase < 200) m_tready <= ($urandom_range(0, 7) == 0);
			else m_tready <= ((phase % 7) < 4);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) sb.check_beat(m_tdata, m_tuser);
			if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
		end else begin
			idle_cycles <= 0;
		end
	end

	initial begin
		@(posedge clk);
		while (!(stim_done && sb.pending.size() == 0)) @(posedge clk);
		repeat (100) @(posedge clk);
		if (sb.errors == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end

	initial begin
		wait (idle_cycles >= 2000);
		$display("DONE: errors detected");
		$finish;
	end
endmodule
